/* rtl/b64e_pkg.sv */
// Shared types, constants and the character mapping of the base64 encoder.
// No dependencies; every other file takes names from here by scope.
package b64e_pkg;

  localparam logic [6:0] PAD_CHAR  = 7'h3D;
  localparam logic [5:0] SIX_MASK  = 6'h3F;
  localparam int         QDEPTH    = 2;

  localparam logic [1:0] HELD_ONE   = 2'd1;
  localparam logic [1:0] HELD_TWO   = 2'd2;
  localparam logic [1:0] HELD_THREE = 2'd3;

  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  held;
    logic        fin;
  } grp_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0] pend_cnt;
  } front_stat_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2B;
      default:       c = 8'h2F;
    endcase
    return c[6:0];
  endfunction

endpackage

/* rtl/b64e_front.sv */
// Front end: accepts input bytes, gathers them into groups of three.
// Pushes a complete or final group to the queue. Uses b64e_pkg.
module b64e_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_final_byte,
  output logic                  push_valid,
  input  logic                  push_ready,
  output b64e_pkg::grp_t        push_data,
  output b64e_pkg::front_stat_t stat
);

  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  held;
  logic        emit;
  logic        take;

  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    held            = pend_cnt_r + 2'd1;
    push_data.held  = held;
    push_data.fin   = in_final_byte;
    case (pend_cnt_r)
      2'd0:    push_data.group = {in_data_byte, 16'h0000};
      2'd1:    push_data.group = {pend_r[15:8], in_data_byte, 8'h00};
      default: push_data.group = {pend_r[15:8], pend_r[7:0], in_data_byte};
    endcase
    emit       = in_final_byte || (held == b64e_pkg::HELD_THREE);
    push_valid = in_valid && emit;

    pend_cnt_nxt = pend_cnt_r;
    pend_nxt     = pend_r;
    if (take) begin
      if (emit) begin
        pend_cnt_nxt = 2'd0;
        pend_nxt     = 16'h0000;
      end else if (pend_cnt_r == 2'd0) begin
        pend_cnt_nxt = 2'd1;
        pend_nxt     = {in_data_byte, 8'h00};
      end else begin
        pend_cnt_nxt = 2'd2;
        pend_nxt     = {pend_r[15:8], in_data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      pend_r     <= 16'h0000;
    end else begin
      pend_cnt_r <= pend_cnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

  assign stat.pend_cnt = pend_cnt_r;

endmodule

/* rtl/b64e_queue.sv */
// Two-entry group queue between front and back ends.
// Uses b64e_pkg for the entry type and depth.
module b64e_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  b64e_pkg::grp_t    push_data,
  output logic              head_valid,
  input  logic              pop,
  output b64e_pkg::grp_t    head_data,
  output b64e_pkg::q_stat_t stat
);

  b64e_pkg::grp_t ent_r [b64e_pkg::QDEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != 2'(b64e_pkg::QDEPTH));
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign stat.full  = !push_ready;
  assign stat.empty = !head_valid;

endmodule

/* rtl/b64e_back.sv */
// Back end: serializes the queue head into four characters, one a beat.
// Drives the registered result channel. Uses b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  b64e_pkg::grp_t head_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_code_char,
  output logic           out_run_end,
  output logic           out_stream_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       run_end_r, run_end_nxt;
  logic       stream_end_r, stream_end_nxt;
  logic       load;
  logic       step;
  logic [5:0] sextet;

  assign load = !out_valid_r || out_ready;
  assign step = load && head_valid;
  assign pop  = step && (idx_r == 2'd3);

  always_comb begin
    case (idx_r)
      2'd0:    sextet = head_data.group[23:18] & b64e_pkg::SIX_MASK;
      2'd1:    sextet = head_data.group[17:12] & b64e_pkg::SIX_MASK;
      2'd2:    sextet = head_data.group[11:6]  & b64e_pkg::SIX_MASK;
      default: sextet = head_data.group[5:0]   & b64e_pkg::SIX_MASK;
    endcase
    char_nxt = b64e_pkg::b64_char(sextet);
    if ((idx_r == 2'd2) && (head_data.held == b64e_pkg::HELD_ONE)) begin
      char_nxt = b64e_pkg::PAD_CHAR;
    end
    if ((idx_r == 2'd3) && (head_data.held != b64e_pkg::HELD_THREE)) begin
      char_nxt = b64e_pkg::PAD_CHAR;
    end
    run_end_nxt    = (idx_r == 2'd3);
    stream_end_nxt = run_end_nxt && head_data.fin;
    out_valid_nxt  = load ? head_valid : out_valid_r;
    idx_nxt        = step ? idx_r + 2'd1 : idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      char_r       <= char_nxt;
      run_end_r    <= run_end_nxt;
      stream_end_r <= stream_end_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_char  = char_r;
  assign out_run_end    = run_end_r;
  assign out_stream_end = stream_end_r;

endmodule

/* rtl/base64_stream_encoder.sv */
// Top level of the streaming base64 encoder: front end, group queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Bytes enter one a beat, each with a last-byte flag. Every third byte of a
// group, and every byte flagged last, produces four ASCII characters (missing
// positions padded with '='), sent one a beat with run_end on the fourth and
// stream_end on the fourth of the last group. The front end takes one byte a
// cycle while the two-entry queue has room; the back end sends one character
// a cycle while out_ready allows, so sustained throughput on full groups is
// set by the single-character result channel. The group that a byte closes is
// written to the queue, then its first character is registered in the back end.
module base64_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_code_char,
  output logic       out_run_end,
  output logic       out_stream_end
);

  logic                  push_valid;
  logic                  push_ready;
  b64e_pkg::grp_t        push_data;
  logic                  head_valid;
  b64e_pkg::grp_t        head_data;
  logic                  pop;
  b64e_pkg::q_stat_t     q_stat;
  b64e_pkg::front_stat_t f_stat;

  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data),
    .stat          (f_stat)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data),
    .stat       (q_stat)
  );

  b64e_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_data      (head_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_char  (out_code_char),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end)
  );

  a_stream_end_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_end)
    else $error("stream_end without run_end");

  a_pad_runs_to_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_end && (out_code_char == b64e_pkg::PAD_CHAR)
    |=> out_valid && (out_code_char == b64e_pkg::PAD_CHAR))
    else $error("pad not followed by pad");

  a_pend_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    f_stat.pend_cnt != 2'd3)
    else $error("front holds three bytes");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
